FILE: rtl/nau_pkg.sv
// ----------------------------------------------------------------------------
// nau_pkg
// shared types, constants and the tanh table for the activation unit
// ----------------------------------------------------------------------------
`default_nettype none

package nau_pkg;

    localparam int TANH_ENTRIES = 256;
    localparam int TANH_IDX_W   = $clog2(TANH_ENTRIES);
    localparam int NUM_STAGES   = 8;

    localparam logic [15:0] LEAKY_SLOPE_RESET = 16'd655;
    localparam logic [31:0] GELU_C1 = 32'd3426888095;
    localparam logic [27:0] GELU_C2 = 28'd192049463;
    localparam logic [63:0] ONE_Q31 = 64'd2147483648;

    typedef enum logic [1:0] {
        OP_RELU  = 2'd0,
        OP_GELU  = 2'd1,
        OP_LEAKY = 2'd2,
        OP_PASS  = 2'd3
    } t_op;

    // sideband that travels with every sample through the pipe
    typedef struct packed {
        logic        last;
        logic        is_gelu;
        logic        neg;
        logic        big;
        logic [15:0] mag;
        logic [15:0] simple;
    } t_side;

    // upper entries round to exactly one, so each entry holds 17 bits
    typedef logic [TANH_ENTRIES:0][16:0] t_tanh_rom;

    // bitwise long division, elaboration only
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // tanh(8*i/TANH_ENTRIES) in unsigned q16
    function automatic t_tanh_rom tanh_rom_build();
        t_tanh_rom   rom;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] step;
        logic [63:0] e;
        logic [63:0] den;
        term = ONE_Q31;
        sum  = ONE_Q31;
        for (int k = 1; k <= 40; k++) begin
            if (term != 64'd0) begin
                term = udiv64(term * 64'd16, 64'(TANH_ENTRIES) * 64'(k));
                if (k[0]) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
        end
        step   = sum;
        e      = ONE_Q31;
        rom[0] = 17'd0;
        for (int i = 1; i <= TANH_ENTRIES; i++) begin
            e      = (e * step + (ONE_Q31 >> 1)) >> 31;
            den    = ONE_Q31 + e;
            rom[i] = 17'(udiv64(((ONE_Q31 - e) << 16) + (den >> 1), den));
        end
        return rom;
    endfunction

    localparam t_tanh_rom TANH_ROM = tanh_rom_build();

endpackage

`default_nettype wire

FILE: rtl/nau_front.sv
// ----------------------------------------------------------------------------
// nau_front
// first stage: magnitude, relu / leaky / pass results and the square term
// ----------------------------------------------------------------------------
`default_nettype none

module nau_front (
    input  wire logic                i_clk,
    input  wire logic                i_ce,
    input  wire nau_pkg::t_op        i_op,
    input  wire logic signed [15:0]  i_sample,
    input  wire logic                i_last,
    input  wire logic [15:0]         i_slope,
    output nau_pkg::t_side           o_side,
    output logic [21:0]              o_a2
);

    nau_pkg::t_side r_side;
    nau_pkg::t_side n_side;
    logic [21:0]    r_a2;
    logic [21:0]    n_a2;
    logic [15:0]    w_mag;
    logic [32:0]    w_lk_prod;
    logic [15:0]    w_lk_mag;
    logic           w_neg;
    logic           w_pos;

    always_comb begin
        w_neg     = i_sample[15];
        w_pos     = !w_neg && (i_sample != 16'sd0);
        w_mag     = w_neg ? 16'(16'd0 - i_sample) : i_sample;
        w_lk_prod = 33'(w_mag) * 33'(i_slope) + 33'd32768;
        w_lk_mag  = w_lk_prod[31:16];

        n_side.last    = i_last;
        n_side.is_gelu = (i_op == nau_pkg::OP_GELU);
        n_side.neg     = w_neg;
        n_side.big     = (w_mag[15:11] != 5'd0);
        n_side.mag     = w_mag;
        case (i_op)
            nau_pkg::OP_RELU:  n_side.simple = w_pos ? i_sample : 16'd0;
            nau_pkg::OP_LEAKY: n_side.simple = w_pos ? i_sample : 16'(16'd0 - w_lk_mag);
            nau_pkg::OP_PASS:  n_side.simple = i_sample;
            default:           n_side.simple = 16'd0;
        endcase

        n_a2 = 22'(w_mag[10:0]) * 22'(w_mag[10:0]);
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_side <= n_side;
            r_a2   <= n_a2;
        end
    end

    assign o_side = r_side;
    assign o_a2   = r_a2;

endmodule

`default_nettype wire

FILE: rtl/nau_poly.sv
// ----------------------------------------------------------------------------
// nau_poly
// four stages forming the tanh argument sqrt(2/pi)*(x + 0.044715*x^3) in q24
// ----------------------------------------------------------------------------
`default_nettype none

module nau_poly (
    input  wire logic            i_clk,
    input  wire logic [3:0]      i_ce,
    input  wire nau_pkg::t_side  i_side,
    input  wire logic [21:0]     i_a2,
    output nau_pkg::t_side       o_side,
    output logic [28:0]          o_u
);

    nau_pkg::t_side r_side2;
    nau_pkg::t_side r_side3;
    nau_pkg::t_side r_side4;
    nau_pkg::t_side r_side5;
    logic [32:0]    r_a3;
    logic [28:0]    r_term;
    logic [28:0]    r_inner;
    logic [28:0]    r_u;
    logic [32:0]    n_a3;
    logic [61:0]    w_cube_sum;
    logic [28:0]    n_term;
    logic [28:0]    n_inner;
    logic [61:0]    w_arg_sum;
    logic [28:0]    n_u;

    always_comb begin
        n_a3       = 33'(i_a2) * 33'(i_side.mag[10:0]);
        w_cube_sum = 62'(r_a3) * 62'(nau_pkg::GELU_C2) + 62'h80000000;
        n_term     = w_cube_sum[60:32];
        n_inner    = 29'({r_side3.mag[10:0], 16'd0}) + r_term;
        w_arg_sum  = 62'(r_inner) * 62'(nau_pkg::GELU_C1) + 62'h80000000;
        n_u        = w_arg_sum[60:32];
    end

    always_ff @(posedge i_clk) begin
        if (i_ce[0]) begin
            r_side2 <= i_side;
            r_a3    <= n_a3;
        end
        if (i_ce[1]) begin
            r_side3 <= r_side2;
            r_term  <= n_term;
        end
        if (i_ce[2]) begin
            r_side4 <= r_side3;
            r_inner <= n_inner;
        end
        if (i_ce[3]) begin
            r_side5 <= r_side4;
            r_u     <= n_u;
        end
    end

    assign o_side = r_side5;
    assign o_u    = r_u;

endmodule

`default_nettype wire

FILE: rtl/nau_tanh.sv
// ----------------------------------------------------------------------------
// nau_tanh
// table lookup and linear interpolation of tanh, saturating to one
// ----------------------------------------------------------------------------
`default_nettype none

module nau_tanh (
    input  wire logic            i_clk,
    input  wire logic [1:0]      i_ce,
    input  wire nau_pkg::t_side  i_side,
    input  wire logic [28:0]     i_u,
    output nau_pkg::t_side       o_side,
    output logic [16:0]          o_t
);

    localparam int IDX_W = nau_pkg::TANH_IDX_W;
    localparam int FRAC_W = 27 - IDX_W;

    nau_pkg::t_side       r_side6;
    nau_pkg::t_side       r_side7;
    logic [16:0]          r_lo;
    logic [15:0]          r_diff;
    logic [FRAC_W-1:0]    r_frac;
    logic                 r_sat;
    logic [16:0]          r_t;
    logic [IDX_W:0]       w_lo_idx;
    logic [IDX_W:0]       w_hi_idx;
    logic [16:0]          w_lo;
    logic [16:0]          w_hi;
    logic                 n_sat;
    logic [FRAC_W+15:0]   w_interp_sum;
    logic [16:0]          n_t;

    always_comb begin
        w_lo_idx = {1'b0, i_u[FRAC_W +: IDX_W]};
        w_hi_idx = w_lo_idx + (IDX_W+1)'(1);
        w_lo     = nau_pkg::TANH_ROM[w_lo_idx];
        w_hi     = nau_pkg::TANH_ROM[w_hi_idx];
        n_sat    = i_side.big || (i_u[28:FRAC_W+IDX_W] != '0);

        w_interp_sum = (FRAC_W+16)'(r_diff) * (FRAC_W+16)'(r_frac)
                     + ((FRAC_W+16)'(1) << (FRAC_W - 1));
        n_t = r_sat ? 17'h10000
                    : r_lo + 17'(w_interp_sum[FRAC_W +: 16]);
    end

    always_ff @(posedge i_clk) begin
        if (i_ce[0]) begin
            r_side6 <= i_side;
            r_lo    <= w_lo;
            r_diff  <= 16'(w_hi - w_lo);
            r_frac  <= i_u[FRAC_W-1:0];
            r_sat   <= n_sat;
        end
        if (i_ce[1]) begin
            r_side7 <= r_side6;
            r_t     <= n_t;
        end
    end

    assign o_side = r_side7;
    assign o_t    = r_t;

endmodule

`default_nettype wire

FILE: rtl/nau_out.sv
// ----------------------------------------------------------------------------
// nau_out
// final stage: gelu product and rounding, op select and saturation
// ----------------------------------------------------------------------------
`default_nettype none

module nau_out (
    input  wire logic            i_clk,
    input  wire logic            i_ce,
    input  wire nau_pkg::t_side  i_side,
    input  wire logic [16:0]     i_t,
    output logic [15:0]          o_result,
    output logic                 o_last
);

    logic [15:0]        r_result;
    logic               r_last;
    logic [17:0]        w_gain;
    logic [33:0]        w_prod;
    logic [16:0]        w_mag;
    logic signed [17:0] w_gelu;
    logic [15:0]        n_result;

    always_comb begin
        w_gain = i_side.neg ? 18'h10000 - 18'(i_t) : 18'h10000 + 18'(i_t);
        w_prod = 34'(i_side.mag) * 34'(w_gain) + 34'h10000;
        w_mag  = w_prod[33:17];
        w_gelu = i_side.neg ? -$signed({1'b0, w_mag}) : $signed({1'b0, w_mag});
        if (!i_side.is_gelu) begin
            n_result = i_side.simple;
        end else if (w_gelu > 18'sd32767) begin
            n_result = 16'h7fff;
        end else if (w_gelu < -18'sd32768) begin
            n_result = 16'h8000;
        end else begin
            n_result = w_gelu[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_result <= n_result;
            r_last   <= i_side.last;
        end
    end

    assign o_result = r_result;
    assign o_last   = r_last;

endmodule

`default_nettype wire

FILE: rtl/neural_activation_unit.sv
// ----------------------------------------------------------------------------
// neural_activation_unit
// element-wise relu, gelu (tanh form), leaky relu and pass-through on signed q8.8 samples
// ----------------------------------------------------------------------------
// channel   direction  tdata               tuser    tlast
// s_axis    in         sample_in [15:0]    op [1:0] last_in
// m_axis    out        result_out [15:0]   -        last_out
// cfg       in         leaky_slope [15:0]  -        -
//
// eight register stages, one sample per clock while m_axis does not stall
// the tanh lookup, interpolation and the cubic term fill the stage count
// each stage loads whenever it is empty or the stage after it moves, so
// a stall on m_axis only backs up as far as the first empty stage
// reset clears the stage valid bits and sets leaky_slope to 655
// ----------------------------------------------------------------------------
`default_nettype none

module neural_activation_unit (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [15:0]  s_axis_tdata,   // [15:0] sample_in
    input  wire logic [1:0]   s_axis_tuser,   // [1:0] op
    input  wire logic         s_axis_tlast,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [15:0]       m_axis_tdata,   // [15:0] result_out
    output logic              m_axis_tlast,
    input  wire logic         i_cfg_we,
    input  wire logic [15:0]  i_cfg_wdata
);

    localparam int N = nau_pkg::NUM_STAGES;

    logic [N:1]     r_valid;
    logic [N+1:1]   w_ce;
    logic [15:0]    r_leaky_slope;
    nau_pkg::t_side w_side1;
    nau_pkg::t_side w_side5;
    nau_pkg::t_side w_side7;
    logic [21:0]    w_a2;
    logic [28:0]    w_u;
    logic [16:0]    w_t;

    always_comb begin
        w_ce[N+1] = m_axis_tready;
        for (int k = N; k >= 1; k--) begin
            w_ce[k] = !r_valid[k] || w_ce[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid       <= '0;
            r_leaky_slope <= nau_pkg::LEAKY_SLOPE_RESET;
        end else begin
            if (i_cfg_we) begin
                r_leaky_slope <= i_cfg_wdata;
            end
            if (w_ce[1]) begin
                r_valid[1] <= s_axis_tvalid;
            end
            for (int k = 2; k <= N; k++) begin
                if (w_ce[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
        end
    end

    nau_front u_front (
        .i_clk    (i_clk),
        .i_ce     (w_ce[1]),
        .i_op     (nau_pkg::t_op'(s_axis_tuser)),
        .i_sample (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .i_slope  (r_leaky_slope),
        .o_side   (w_side1),
        .o_a2     (w_a2)
    );

    nau_poly u_poly (
        .i_clk  (i_clk),
        .i_ce   (w_ce[5:2]),
        .i_side (w_side1),
        .i_a2   (w_a2),
        .o_side (w_side5),
        .o_u    (w_u)
    );

    nau_tanh u_tanh (
        .i_clk  (i_clk),
        .i_ce   (w_ce[7:6]),
        .i_side (w_side5),
        .i_u    (w_u),
        .o_side (w_side7),
        .o_t    (w_t)
    );

    nau_out u_out (
        .i_clk    (i_clk),
        .i_ce     (w_ce[8]),
        .i_side   (w_side7),
        .i_t      (w_t),
        .o_result (m_axis_tdata),
        .o_last   (m_axis_tlast)
    );

    // no transaction is taken while reset is held
    assign s_axis_tready = i_rst_n && w_ce[1];
    assign m_axis_tvalid = r_valid[N];

endmodule

`default_nettype wire
